// File: src/nic_pkg.sv
// Package for the nested interval counter: command codes, status codes and
// the control/status structs between controller and datapath. No dependencies.
package nic_pkg;

   localparam int CNT_W  = 10;
   localparam int SLOT_W = 10;
   localparam int STS_W  = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [STS_W-1:0] STATUS_OK  = 2'd0;
   localparam logic [STS_W-1:0] STATUS_BAD = 2'd1;
   localparam logic [STS_W-1:0] STATUS_OVF = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic idle;
      logic start;
      logic row_rd;
      logic row_cap;
      logic scan_rd;
      logic wr_res;
      logic finish;
   } nic_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go;
      logic row_end;
      logic scan_end;
   } nic_sts_type;

endpackage

// File: src/nic_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read; the read data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/nic_ctrl.sv
// Controller state machine for the nested interval counter.
// Depends on nic_pkg.
module nic_ctrl
   import nic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  nic_sts_type sts,
   output nic_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROW   = 5'b00010,
      S_CAP   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.go) begin
               cmd.start = 1'b1;
               state_in  = S_ROW;
            end
         end
         S_ROW: begin
            if (sts.row_end) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.row_rd = 1'b1;
               state_in   = S_CAP;
            end
         end
         S_CAP: begin
            cmd.row_cap = 1'b1;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (sts.scan_end) begin
               state_in = S_WRITE;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.wr_res = 1'b1;
            state_in   = S_ROW;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/nic_dpath.sv
// Datapath of the nested interval counter: interval and result memories,
// counters, the pairwise compare and the response register. Depends on nic_pkg, nic_ram.
module nic_dpath
   import nic_pkg::*;
#(
   parameter int MAX_INTERVALS = 1024,
   parameter int COORD_BITS    = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nic_cmd_type           cmd,
   output nic_sts_type           sts,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [COORD_BITS-1:0] req_left_end,
   input  logic [COORD_BITS-1:0] req_right_end,
   input  logic                  req_final_load,
   input  logic [SLOT_W-1:0]     req_read_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_contains_count,
   output logic [CNT_W-1:0]      rsp_contained_count,
   output logic [STS_W-1:0]      rsp_status
);

   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   logic          accept, load_acc, read_acc;
   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in, ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [AW-1:0] jd_ff;
   logic          vd_ff;
   logic [COORD_BITS-1:0] li_ff, ri_ff;
   logic [CNT_W-1:0] cin_ff, cin_in, cby_ff, cby_in;
   logic          pend_ff, pend_in;
   logic [STS_W-1:0] pst_ff, pst_in;
   logic          rv_ff, rv_in;
   logic [CNT_W-1:0] rc_ff, rb_ff;
   logic [STS_W-1:0] rs_ff;
   logic          capture;

   logic          iv_we, iv_re;
   logic [AW-1:0] iv_waddr, iv_raddr;
   logic [2*COORD_BITS-1:0] iv_rdata;
   logic [COORD_BITS-1:0] lj, rj;
   logic [2*CNT_W-1:0] res_rdata;
   logic [AW-1:0] slot_addr;
   logic          slot_bad;

   assign req_ready = cmd.idle && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign load_acc  = accept && (req_cmd == CMD_LOAD);
   assign read_acc  = accept && (req_cmd == CMD_READ);

   assign sts.go       = load_acc && req_final_load;
   assign sts.row_end  = (i_ff == count_ff);
   assign sts.scan_end = (j_ff == count_ff);

   // Interval store: written by loads, read for the row and scanned words.
   assign iv_we    = load_acc && (done_ff || (count_ff != CW'(MAX_INTERVALS)));
   assign iv_waddr = done_ff ? '0 : count_ff[AW-1:0];
   assign iv_re    = cmd.row_rd || cmd.row_cap || cmd.scan_rd;
   assign iv_raddr = cmd.row_rd ? i_ff[AW-1:0] : j_ff[AW-1:0];

   nic_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_INTERVALS)) u_iv_ram (
      .clock (clock),
      .we    (iv_we),
      .waddr (iv_waddr),
      .wdata ({req_left_end, req_right_end}),
      .re    (iv_re),
      .raddr (iv_raddr),
      .rdata (iv_rdata)
   );

   assign lj = iv_rdata[2*COORD_BITS-1:COORD_BITS];
   assign rj = iv_rdata[COORD_BITS-1:0];

   // Result store: written at the end of each row, read by read words.
   assign slot_addr = AW'(req_read_slot);
   assign slot_bad  = !done_ff || (32'(req_read_slot) >= 32'(count_ff));

   nic_ram #(.WIDTH(2 * CNT_W), .DEPTH(MAX_INTERVALS)) u_res_ram (
      .clock (clock),
      .we    (cmd.wr_res),
      .waddr (i_ff[AW-1:0]),
      .wdata ({cin_ff, cby_ff}),
      .re    (read_acc),
      .raddr (slot_addr),
      .rdata (res_rdata)
   );

   // Load bookkeeping and completion flag.
   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      ovf_in   = ovf_ff;
      if (load_acc) begin
         if (done_ff) begin
            count_in = CW'(1);
            done_in  = 1'b0;
            ovf_in   = 1'b0;
         end else if (count_ff != CW'(MAX_INTERVALS)) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         done_in = 1'b1;
      end
   end

   // Row and scan counters and the two containment counts.
   always_comb begin
      logic exact, hit_in, hit_by;
      i_in   = i_ff;
      j_in   = j_ff;
      cin_in = cin_ff;
      cby_in = cby_ff;
      exact  = (lj == li_ff) && (rj == ri_ff);
      hit_in = (lj >= li_ff) && (rj <= ri_ff) && (!exact || (jd_ff > i_ff[AW-1:0]));
      hit_by = (lj <= li_ff) && (rj >= ri_ff) && (!exact || (jd_ff < i_ff[AW-1:0]));
      if (cmd.start) begin
         i_in = '0;
      end
      // The scan of every row starts at the first interval.
      if (cmd.row_rd) begin
         j_in = '0;
      end
      if (cmd.row_cap) begin
         j_in   = CW'(1);
         cin_in = '0;
         cby_in = '0;
      end else if (cmd.scan_rd) begin
         j_in = j_ff + CW'(1);
      end
      if (vd_ff) begin
         cin_in = cin_ff + CNT_W'(hit_in);
         cby_in = cby_ff + CNT_W'(hit_by);
      end
      if (cmd.wr_res) begin
         i_in = i_ff + CW'(1);
      end
   end

   // Read words wait for the registered memory read, then fill a free response register.
   assign capture = pend_ff && (!rv_ff || rsp_ready);
   always_comb begin
      pend_in = pend_ff;
      pst_in  = pst_ff;
      rv_in   = rv_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      if (capture) begin
         pend_in = 1'b0;
         rv_in   = 1'b1;
      end
      if (read_acc) begin
         pend_in = 1'b1;
         pst_in  = slot_bad ? STATUS_BAD : (ovf_ff ? STATUS_OVF : STATUS_OK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         vd_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
         ovf_ff   <= ovf_in;
         vd_ff    <= cmd.row_cap || cmd.scan_rd;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      jd_ff  <= j_ff[AW-1:0];
      cin_ff <= cin_in;
      cby_ff <= cby_in;
      pst_ff <= pst_in;
      if (cmd.row_cap) begin
         li_ff <= lj;
         ri_ff <= rj;
      end
      if (capture) begin
         rs_ff <= pst_ff;
         rc_ff <= (pst_ff == STATUS_BAD) ? '0 : res_rdata[2*CNT_W-1:CNT_W];
         rb_ff <= (pst_ff == STATUS_BAD) ? '0 : res_rdata[CNT_W-1:0];
      end
   end

   assign rsp_valid           = rv_ff;
   assign rsp_contains_count  = rc_ff;
   assign rsp_contained_count = rb_ff;
   assign rsp_status          = rs_ff;

endmodule

// File: src/nested_interval_counter.sv
// Top level of the nested interval counter.
// Depends on nic_pkg, nic_ctrl, nic_dpath.

// Load words (cmd 0) are taken one per cycle while req_ready is high and stored
// in load order; the word flagged final_load closes the set, and the block then
// compares every interval with every other one, with req_ready low meanwhile.
// The comparisons run on one shared compare unit fed by one read port of the
// interval memory, one interval per cycle. Read words (cmd 1) pass through the
// registered read of the result memory, and no new word is taken while one is
// pending; a response can wait in its output register while loads go on.
module nested_interval_counter
   import nic_pkg::*;
#(
   parameter int MAX_INTERVALS = 1024,
   parameter int COORD_BITS    = 30
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [COORD_BITS-1:0] req_left_end,
   input  logic [COORD_BITS-1:0] req_right_end,
   input  logic                  req_final_load,
   input  logic [SLOT_W-1:0]     req_read_slot,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CNT_W-1:0]      rsp_contains_count,
   output logic [CNT_W-1:0]      rsp_contained_count,
   output logic [STS_W-1:0]      rsp_status
);

   nic_cmd_type cmd;
   nic_sts_type sts;

   // Controller.
   nic_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Datapath.
   nic_dpath #(.MAX_INTERVALS(MAX_INTERVALS), .COORD_BITS(COORD_BITS)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_left_end        (req_left_end),
      .req_right_end       (req_right_end),
      .req_final_load      (req_final_load),
      .req_read_slot       (req_read_slot),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_contains_count  (rsp_contains_count),
      .rsp_contained_count (rsp_contained_count),
      .rsp_status          (rsp_status)
   );

endmodule

// File: src/nic_checker.sv
// Port checker for the nested interval counter, bound to the top level.
// Depends on nic_pkg.
module nic_checker
   import nic_pkg::*;
#(
   parameter int COORD_BITS = 30
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_cmd,
   input logic [COORD_BITS-1:0] req_left_end,
   input logic [COORD_BITS-1:0] req_right_end,
   input logic                  req_final_load,
   input logic [SLOT_W-1:0]     req_read_slot,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [CNT_W-1:0]      rsp_contains_count,
   input logic [CNT_W-1:0]      rsp_contained_count,
   input logic [STS_W-1:0]      rsp_status
);

   // A stalled response holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_contains_count) && $stable(rsp_contained_count))
      else $error("response changed while stalled");

   // The status field never carries the unused code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_BAD
         || rsp_status == STATUS_OVF))
      else $error("bad status code");

   // A rejected read returns zero counts.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD |->
         rsp_contains_count == '0 && rsp_contained_count == '0)
      else $error("nonzero counts on rejected read");

   // A final load starts the computation, so the next word waits.
   a_final_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_LOAD && req_final_load |=> !req_ready)
      else $error("input taken right after final load");

endmodule

bind nested_interval_counter nic_checker #(.COORD_BITS(COORD_BITS)) u_nic_checker (.*);

// File: tb/tb_nested_interval_counter.sv
// Testbench for nested_interval_counter: loads interval sets, reads back both
// nesting counts per slot and checks them against a direct pairwise count.
// Depends on nic_pkg and the nested_interval_counter RTL.
`timescale 1ns / 100ps

module tb_nested_interval_counter;
   import nic_pkg::*;

   localparam int CAP        = 1024;
   localparam int IDLE_LIMIT = 5000000;

   typedef struct {
      logic [CNT_W-1:0] contains;
      logic [CNT_W-1:0] contained;
      logic [STS_W-1:0] status;
   } nest_counts_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_cmd = CMD_LOAD;
   logic [29:0]       req_left_end = '0;
   logic [29:0]       req_right_end = '0;
   logic              req_final_load = 1'b0;
   logic [SLOT_W-1:0] req_read_slot = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CNT_W-1:0]  rsp_contains_count;
   logic [CNT_W-1:0]  rsp_contained_count;
   logic [STS_W-1:0]  rsp_status;

   // Predicted state of the block.
   logic [29:0]      set_left [CAP];
   logic [29:0]      set_right [CAP];
   logic [CNT_W-1:0] inner_tally [CAP];
   logic [CNT_W-1:0] outer_tally [CAP];
   int               set_size = 0;
   bit               set_done = 1'b0;
   bit               set_overflow = 1'b0;

   nest_counts_type pending_counts[$];
   bit           quiet = 1'b0;
   bit           failed = 1'b0;
   int           words_sent = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;

   nested_interval_counter DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_left_end(req_left_end), .req_right_end(req_right_end),
      .req_final_load(req_final_load), .req_read_slot(req_read_slot),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_contains_count(rsp_contains_count),
      .rsp_contained_count(rsp_contained_count), .rsp_status(rsp_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Order: left ascending, right descending, then load order.
   function automatic bit sorts_first(int a, int b);
      if (set_left[a] != set_left[b]) return set_left[a] < set_left[b];
      if (set_right[a] != set_right[b]) return set_right[a] > set_right[b];
      return a < b;
   endfunction

   // Count, for every kept interval, the intervals it holds and those holding it.
   function automatic void tally_nesting();
      int inner;
      int outer;
      for (int i = 0; i < set_size; i++) begin
         inner = 0;
         outer = 0;
         for (int j = 0; j < set_size; j++) begin
            if (j == i) continue;
            if (sorts_first(i, j) && set_right[j] <= set_right[i]) inner++;
            if (sorts_first(j, i) && set_right[j] >= set_right[i]) outer++;
         end
         inner_tally[i] = inner[CNT_W-1:0];
         outer_tally[i] = outer[CNT_W-1:0];
      end
   endfunction

   // Update the prediction for one accepted word.
   function automatic void predict_word(logic cmd, logic [29:0] lo, logic [29:0] hi,
                                        logic last, logic [SLOT_W-1:0] slot);
      nest_counts_type c;
      if (cmd == CMD_LOAD) begin
         if (set_done) begin
            set_size = 0;
            set_done = 1'b0;
            set_overflow = 1'b0;
         end
         if (set_size < CAP) begin
            set_left[set_size] = lo;
            set_right[set_size] = hi;
            set_size++;
         end else begin
            set_overflow = 1'b1;
         end
         if (last) begin
            tally_nesting();
            set_done = 1'b1;
         end
      end else begin
         if (!set_done || slot >= set_size) begin
            c.contains = '0;
            c.contained = '0;
            c.status = STATUS_BAD;
         end else begin
            c.contains = inner_tally[slot];
            c.contained = outer_tally[slot];
            c.status = set_overflow ? STATUS_OVF : STATUS_OK;
         end
         pending_counts = {pending_counts, c};
      end
   endfunction

   // Send one word, with an occasional idle burst before it.
   task automatic send_word(logic cmd, logic [29:0] lo, logic [29:0] hi,
                            logic last, logic [SLOT_W-1:0] slot);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_left_end <= lo;
      req_right_end <= hi;
      req_final_load <= last;
      req_read_slot <= slot;
      do @(posedge clock); while (!req_ready);
      predict_word(cmd, lo, hi, last, slot);
      words_sent++;
   endtask

   task automatic load_interval(logic [29:0] lo, logic [29:0] hi, logic last);
      send_word(CMD_LOAD, lo, hi, last, SLOT_W'($urandom));
   endtask

   task automatic read_slot(int slot);
      send_word(CMD_READ, 30'($urandom), 30'($urandom), 1'($urandom), SLOT_W'(slot));
   endtask

   task automatic read_all(int extra);
      for (int s = 0; s < set_size + extra; s++) read_slot(s);
   endtask

   // Field extremes, reversed intervals, early reads and out-of-range reads.
   task automatic test_extremes();
      read_slot(0);
      load_interval(30'h0, 30'h3FFFFFFF, 1'b0);
      read_slot(0);
      load_interval(30'h3FFFFFFF, 30'h3FFFFFFF, 1'b0);
      load_interval(30'h3FFFFFFF, 30'h0, 1'b0);
      load_interval(30'h15555555, 30'h2AAAAAAA, 1'b0);
      load_interval(30'h0, 30'h0, 1'b1);
      read_all(2);
      read_slot(1023);
   endtask

   // Duplicates keep load order; a new load after completion starts a new set.
   task automatic test_duplicates();
      load_interval(30'd5, 30'd9, 1'b0);
      load_interval(30'd5, 30'd9, 1'b0);
      load_interval(30'd5, 30'd9, 1'b0);
      load_interval(30'd6, 30'd9, 1'b0);
      load_interval(30'd5, 30'd12, 1'b1);
      read_all(1);
      load_interval(30'd1, 30'd2, 1'b1);
      read_all(1);
   endtask

   // Fill the store past capacity; the dropped final load still starts the count.
   task automatic test_overflow();
      for (int i = 0; i < CAP + 2; i++)
         load_interval(30'($urandom_range(0, 200)), 30'($urandom_range(0, 200)),
                       i == CAP + 1);
      for (int k = 0; k < 20; k++) read_slot($urandom_range(0, CAP - 1));
      read_slot(CAP - 1);
      read_slot(0);
      load_interval(30'd3, 30'd4, 1'b1);
      read_all(1);
   endtask

   // Random small sets with reads mixed in; the tail runs without idling.
   task automatic test_random_sets(int target);
      int n;
      int span;
      while (words_sent < target) begin
         if (target - words_sent < 150) quiet = 1'b1;
         n = $urandom_range(1, 12);
         span = ($urandom_range(0, 3) == 0) ? 30'h3FFFFFFF : $urandom_range(3, 30);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) read_slot($urandom_range(0, 1023));
            if ($urandom_range(0, 19) == 0)
               load_interval(30'($urandom), 30'($urandom), i == n - 1);
            else
               load_interval(30'($urandom_range(0, span)), 30'($urandom_range(0, span)),
                             i == n - 1);
         end
         for (int k = 0; k < n + 2; k++)
            read_slot(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, n + 1));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_duplicates();
      test_overflow();
      test_random_sets(1250);
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side stalls in random bursts except in the quiet tail.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each returned word with the oldest prediction.
   always @(posedge clock) begin
      nest_counts_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected result word: exp none, got %0d %0d %0d", $time,
                     rsp_contains_count, rsp_contained_count, rsp_status);
            failed = 1'b1;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_contains_count !== want.contains) begin
               $display("%0t: contains_count exp %0d got %0d", $time,
                        want.contains, rsp_contains_count);
               failed = 1'b1;
            end
            if (rsp_contained_count !== want.contained) begin
               $display("%0t: contained_count exp %0d got %0d", $time,
                        want.contained, rsp_contained_count);
               failed = 1'b1;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, rsp_status);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either side.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
